@@ rtl/core/dnd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the DNS name decompressor.
// Used by dnd_ctrl, dnd_dpath and dns_name_decompressor_unit; no dependencies.
package dnd_pkg;

    localparam int PACKET_BYTES_DEF = 512;
    localparam int MAX_HOPS_DEF     = 32;

    // cursor can reach a full 14-bit pointer target or the store depth (up to 16384)
    localparam int CUR_W  = 15;
    localparam int HOP_W  = 6;
    localparam int LEN_W  = 6;
    localparam int HI_W   = 6;
    localparam int ADDR_W = 9;
    localparam int BYTE_W = 8;
    localparam int CONS_W = 10;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd2;

    localparam logic [1:0]        TAG_PTR  = 2'b11;
    localparam logic [1:0]        TAG_LEN  = 2'b00;
    localparam logic [BYTE_W-1:0] CHAR_DOT = 8'h2E;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_LEN_RD  = 7'b0000010,
        S_LEN_CHK = 7'b0000100,
        S_PTR_CHK = 7'b0001000,
        S_CHR_RD  = 7'b0010000,
        S_CHR_CHK = 7'b0100000,
        S_SPARE   = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_ZERO,
        RES_FAIL,
        RES_END,
        RES_DOT,
        RES_CHR
    } t_res;

    typedef struct packed {
        logic mem_wr;
        logic dec_start;
        logic rd_cur;
        logic rd_next;
        logic take_len;
        logic mark_ptr;
        logic jump;
        t_res res;
    } t_cmd;

    typedef struct packed {
        logic active;
        logic rem_zero;
        logic first_label;
        logic cur_oob;
        logic nxt_oob;
        logic hop_max;
        logic byte_zero;
        logic byte_ptr;
        logic byte_rsv;
    } t_sts;

endpackage

@@ rtl/core/dnd_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the DNS name decompressor: walks length, pointer and character
// bytes one store read at a time. Depends on dnd_pkg.
module dnd_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    input  logic [dnd_pkg::FUNC_W-1:0]  i_func,
    input  dnd_pkg::t_sts               i_sts,
    output logic                        busy,
    output dnd_pkg::t_cmd               o_cmd
);
    import dnd_pkg::*;

    t_state r_state;
    t_state n_state;

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res = RES_NONE;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_func)
                        FUNC_WRITE: begin
                            o_cmd.mem_wr = 1'b1;
                            o_cmd.res    = RES_ZERO;
                        end
                        FUNC_START: begin
                            o_cmd.dec_start = 1'b1;
                            o_cmd.res       = RES_ZERO;
                        end
                        FUNC_FETCH: begin
                            if (!i_sts.active) begin
                                o_cmd.res = RES_FAIL;
                            end else if (!i_sts.rem_zero) begin
                                n_state = S_CHR_RD;
                            end else begin
                                n_state = S_LEN_RD;
                            end
                        end
                        default: begin
                            o_cmd.res = RES_ZERO;
                        end
                    endcase
                end
            end
            S_LEN_RD: begin
                if (i_sts.cur_oob) begin
                    o_cmd.res = RES_FAIL;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_LEN_CHK;
                end
            end
            S_LEN_CHK: begin
                n_state = S_IDLE;
                if (i_sts.byte_zero) begin
                    o_cmd.res = RES_END;
                end else if (i_sts.byte_ptr) begin
                    if (i_sts.nxt_oob) begin
                        o_cmd.res = RES_FAIL;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                        n_state       = S_PTR_CHK;
                    end
                end else if (i_sts.byte_rsv) begin
                    o_cmd.res = RES_FAIL;
                end else if (!i_sts.first_label) begin
                    o_cmd.res = RES_DOT;
                end else begin
                    o_cmd.take_len = 1'b1;
                    n_state        = S_CHR_RD;
                end
            end
            S_PTR_CHK: begin
                o_cmd.mark_ptr = 1'b1;
                if (i_sts.hop_max) begin
                    o_cmd.res = RES_FAIL;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.jump = 1'b1;
                    n_state    = S_LEN_RD;
                end
            end
            S_CHR_RD: begin
                if (i_sts.cur_oob) begin
                    o_cmd.res = RES_FAIL;
                    n_state   = S_IDLE;
                end else begin
                    o_cmd.rd_cur = 1'b1;
                    n_state      = S_CHR_CHK;
                end
            end
            S_CHR_CHK: begin
                o_cmd.res = RES_CHR;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_cur |=> (r_state == S_LEN_CHK || r_state == S_CHR_CHK))
        else $error("store read not followed by a check state");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_next |=> (r_state == S_PTR_CHK))
        else $error("pointer read not followed by pointer check");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.res != RES_NONE) |=> (r_state == S_IDLE))
        else $error("result issued without returning to idle");

endmodule

@@ rtl/core/dnd_dpath.sv @@
`timescale 1ns / 1ps
// Datapath for the DNS name decompressor: packet store, walk registers and
// result registers. Depends on dnd_pkg; driven by dnd_ctrl commands.
module dnd_dpath #(
    parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF,
    parameter int MAX_HOPS     = dnd_pkg::MAX_HOPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  dnd_pkg::t_cmd               i_cmd,
    input  logic [dnd_pkg::ADDR_W-1:0]  i_address,
    input  logic [dnd_pkg::BYTE_W-1:0]  i_data,
    output dnd_pkg::t_sts               o_sts,
    output logic                        o_strobe,
    output logic [dnd_pkg::BYTE_W-1:0]  o_out_char,
    output logic                        o_char_valid,
    output logic                        o_last,
    output logic [dnd_pkg::CONS_W-1:0]  o_consumed_length,
    output logic                        o_error
);
    import dnd_pkg::*;

    localparam int AW = $clog2(PACKET_BYTES);

    logic [BYTE_W-1:0] r_mem [PACKET_BYTES];
    logic [BYTE_W-1:0] r_rdata;
    logic [HI_W-1:0]   r_hi;
    logic [CUR_W-1:0]  r_cursor;
    logic [LEN_W-1:0]  r_rem;
    logic [ADDR_W-1:0] r_start;
    logic [CUR_W-1:0]  r_end;
    logic              r_ptr_seen;
    logic              r_first;
    logic [HOP_W-1:0]  r_hop;
    logic              r_active;
    logic              r_strobe;

    logic [BYTE_W-1:0] r_out_char;
    logic              r_char_valid;
    logic              r_last;
    logic [CONS_W-1:0] r_cons;
    logic              r_err;

    logic [CUR_W-1:0]  addr_ext;
    logic              wr_ok;
    logic [CUR_W-1:0]  cur_nxt;
    logic [CUR_W-1:0]  cur_nxt2;
    logic [AW-1:0]     rd_idx;
    logic [CUR_W-1:0]  target;
    logic [CUR_W-1:0]  end_eff;
    logic [CUR_W-1:0]  span;

    assign addr_ext = CUR_W'(i_address);
    assign wr_ok    = (addr_ext < CUR_W'(PACKET_BYTES));
    assign cur_nxt  = r_cursor + CUR_W'(1);
    assign cur_nxt2 = r_cursor + CUR_W'(2);
    assign rd_idx   = i_cmd.rd_next ? cur_nxt[AW-1:0] : r_cursor[AW-1:0];
    assign target   = CUR_W'({r_hi, r_rdata});
    assign end_eff  = r_ptr_seen ? r_end : cur_nxt;
    assign span     = end_eff - CUR_W'(r_start);

    always_comb begin
        o_sts.active      = r_active;
        o_sts.rem_zero    = (r_rem == '0);
        o_sts.first_label = r_first;
        o_sts.cur_oob     = (r_cursor >= CUR_W'(PACKET_BYTES));
        o_sts.nxt_oob     = (cur_nxt >= CUR_W'(PACKET_BYTES));
        o_sts.hop_max     = (r_hop >= HOP_W'(MAX_HOPS));
        o_sts.byte_zero   = (r_rdata == '0);
        o_sts.byte_ptr    = (r_rdata[BYTE_W-1 -: 2] == TAG_PTR);
        o_sts.byte_rsv    = (r_rdata[BYTE_W-1 -: 2] != TAG_PTR) &&
                            (r_rdata[BYTE_W-1 -: 2] != TAG_LEN);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && wr_ok) begin
            r_mem[addr_ext[AW-1:0]] <= i_data;
        end
        if (i_cmd.rd_cur || i_cmd.rd_next) begin
            r_rdata <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_next) begin
            r_hi <= r_rdata[HI_W-1:0];
        end
        case (i_cmd.res)
            RES_ZERO: begin
                r_out_char   <= '0;
                r_char_valid <= 1'b0;
                r_last       <= 1'b0;
                r_cons       <= '0;
                r_err        <= 1'b0;
            end
            RES_FAIL: begin
                r_out_char   <= '0;
                r_char_valid <= 1'b0;
                r_last       <= 1'b1;
                r_cons       <= '0;
                r_err        <= 1'b1;
            end
            RES_END: begin
                r_out_char   <= '0;
                r_char_valid <= 1'b0;
                r_last       <= 1'b1;
                r_cons       <= span[CONS_W-1:0];
                r_err        <= 1'b0;
            end
            RES_DOT: begin
                r_out_char   <= CHAR_DOT;
                r_char_valid <= 1'b1;
                r_last       <= 1'b0;
                r_cons       <= '0;
                r_err        <= 1'b0;
            end
            RES_CHR: begin
                r_out_char   <= r_rdata;
                r_char_valid <= 1'b1;
                r_last       <= 1'b0;
                r_cons       <= '0;
                r_err        <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor   <= '0;
            r_rem      <= '0;
            r_start    <= '0;
            r_end      <= '0;
            r_ptr_seen <= 1'b0;
            r_first    <= 1'b1;
            r_hop      <= '0;
            r_active   <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= (i_cmd.res != RES_NONE);
            if (i_cmd.dec_start) begin
                r_start    <= i_address;
                r_cursor   <= addr_ext;
                r_rem      <= '0;
                r_end      <= '0;
                r_ptr_seen <= 1'b0;
                r_first    <= 1'b1;
                r_hop      <= '0;
                r_active   <= 1'b1;
            end
            if (i_cmd.take_len) begin
                r_rem    <= r_rdata[LEN_W-1:0];
                r_cursor <= cur_nxt;
            end
            if (i_cmd.mark_ptr && !r_ptr_seen) begin
                r_end      <= cur_nxt2;
                r_ptr_seen <= 1'b1;
            end
            if (i_cmd.jump) begin
                r_hop    <= r_hop + HOP_W'(1);
                r_cursor <= target;
            end
            case (i_cmd.res)
                RES_FAIL: begin
                    r_active <= 1'b0;
                    r_rem    <= '0;
                end
                RES_END: begin
                    r_active <= 1'b0;
                    if (!r_ptr_seen) begin
                        r_end <= cur_nxt;
                    end
                end
                RES_DOT: begin
                    r_first <= 1'b1;
                end
                RES_CHR: begin
                    r_cursor <= cur_nxt;
                    r_rem    <= r_rem - LEN_W'(1);
                    if (r_rem == LEN_W'(1)) begin
                        r_first <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe          = r_strobe;
    assign o_out_char        = r_out_char;
    assign o_char_valid      = r_char_valid;
    assign o_last            = r_last;
    assign o_consumed_length = r_cons;
    assign o_error           = r_err;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rem != '0) |-> r_active)
        else $error("label characters pending with no decode running");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hop <= HOP_W'(MAX_HOPS))
        else $error("pointer hop count beyond limit");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_err) |-> (r_last && !r_char_valid))
        else $error("error beat without last or with a character");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.res == RES_CHR) |=> (r_rem == $past(r_rem) - LEN_W'(1)))
        else $error("label count not stepped on a character beat");

endmodule

@@ rtl/core/dns_name_decompressor_unit.sv @@
`timescale 1ns / 1ps
// Write and start items: result beat in the cycle after accept; unused func codes alike.
// Fetch states: character inside a label CHR_RD, CHR_CHK; no decode running fails in IDLE; a first
// label character LEN_RD, LEN_CHK, CHR_RD, CHR_CHK; dot or terminator LEN_RD, LEN_CHK; each
// pointer followed adds PTR_CHK, LEN_RD, LEN_CHK; a failed bounds or hop check ends the walk there.
// Reset clears the walk state; the packet store is undefined until written, no clear.
module dns_name_decompressor_unit #(
    parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF,
    parameter int MAX_HOPS     = dnd_pkg::MAX_HOPS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [dnd_pkg::FUNC_W-1:0]  i_func,
    input  logic [dnd_pkg::ADDR_W-1:0]  i_address,
    input  logic [dnd_pkg::BYTE_W-1:0]  i_data,
    output logic                        o_strobe,
    output logic [dnd_pkg::BYTE_W-1:0]  o_out_char,
    output logic                        o_char_valid,
    output logic                        o_last,
    output logic [dnd_pkg::CONS_W-1:0]  o_consumed_length,
    output logic                        o_error
);
    import dnd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dnd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    dnd_dpath #(
        .PACKET_BYTES (PACKET_BYTES),
        .MAX_HOPS     (MAX_HOPS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_address         (i_address),
        .i_data            (i_data),
        .o_sts             (sts),
        .o_strobe          (o_strobe),
        .o_out_char        (o_out_char),
        .o_char_valid      (o_char_valid),
        .o_last            (o_last),
        .o_consumed_length (o_consumed_length),
        .o_error           (o_error)
    );

endmodule
